FILE: src/wrst_pkg.sv
// Package for the weekly relay schedule table.
// Holds table sizes, command and status codes, and the entry and request types.
// No dependencies.
`default_nettype none

package wrst_pkg;

    localparam int ENTRIES  = 16;
    localparam int CHANNELS = 6;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W    = $clog2(ENTRIES + 1);

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_SET_EN = 3'd3;
    localparam logic [2:0] CMD_EDIT   = 3'd4;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX   = 2'd1;
    localparam logic [1:0] ST_BAD_CHANNEL = 2'd2;
    localparam logic [1:0] ST_FULL        = 2'd3;

    localparam logic [2:0] LAST_WEEKDAY = 3'd6;

    typedef struct packed {
        logic [2:0] ch;
        logic [4:0] hr;
        logic [5:0] mn;
        logic       on;
        logic       en;
        logic [6:0] days;
    } t_entry;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] index;
        logic [2:0] channel;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
        logic       turn_on;
        logic       enable;
        logic [6:0] day_mask;
    } t_req;

    function automatic logic channel_ok(input logic [2:0] ch);
        return (ch != 3'd0) && ({1'b0, ch} <= 4'(CHANNELS));
    endfunction

endpackage

`default_nettype wire

FILE: src/wrst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; read data holds while no read is enabled.
`default_nettype none

module wrst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/weekly_relay_schedule_table.sv
// Add, unknown commands, skipped ticks and rejected commands go from accept straight to the
// final result state; set enabled and edit first pass the read-modify-write state; remove
// shifts each entry above the removed one down first; a checked tick walks every entry.
// One transaction at a time: the walk reads one stored entry per cycle from the single read
// port of the entry RAM, but waits while a second match needs a busy output register.
// Reset (synchronous, active low) empties the table; RAM contents are not cleared.
`default_nettype none

module weekly_relay_schedule_table
    import wrst_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_command,
    input  wire logic [3:0] i_index,
    input  wire logic [2:0] i_channel,
    input  wire logic [4:0] i_hour,
    input  wire logic [5:0] i_minute,
    input  wire logic [2:0] i_weekday,
    input  wire logic       i_turn_on,
    input  wire logic       i_enable,
    input  wire logic [6:0] i_day_mask,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [1:0]      o_status,
    output logic            o_fire,
    output logic [2:0]      o_relay_channel,
    output logic            o_relay_on,
    output logic            o_last,
    output logic [4:0]      o_entry_count
);

    // Sequencer states: idle/accept, tick walk, remove shift, read-modify-write,
    // final result.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHK   = 5'b00010,
        S_SHIFT = 5'b00100,
        S_RMW   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_req               r_req;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [1:0]         r_status, n_status;
    logic [5:0]         r_cm, n_cm;      // last checked minute
    logic               r_cm_v, n_cm_v;
    // One match is held back so the walk knows whether it is the final one.
    logic               r_hold_v, n_hold_v;
    logic [2:0]         r_hold_ch, n_hold_ch;
    logic               r_hold_on, n_hold_on;

    // output register
    logic               r_out_valid;
    logic [1:0]         r_out_status;
    logic               r_out_fire;
    logic [2:0]         r_out_ch;
    logic               r_out_on;
    logic               r_out_last;
    logic [4:0]         r_out_count;

    logic               accept;
    logic               out_free;
    logic               push;
    logic [1:0]         push_status;
    logic               push_fire;
    logic [2:0]         push_ch;
    logic               push_on;
    logic               push_last;

    // entry RAM port
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    t_entry             wr_data;
    t_entry             rd_data;
    logic [$bits(t_entry)-1:0] rd_bits;

    logic [CNT_W-1:0]   idx_cnt;
    logic [CNT_W-1:0]   nxt;
    logic [6:0]         day_bits;
    logic               match;
    t_entry             mod_entry;

    wrst_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits)
    );

    assign rd_data  = t_entry'(rd_bits);
    assign o_in_stall = (r_state != S_IDLE);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign idx_cnt  = CNT_W'(i_index);

    // Match test on the entry held in the RAM read register; weekday seven hits no day.
    assign day_bits = rd_data.days >> r_req.weekday;
    assign match    = rd_data.en && (r_req.weekday <= LAST_WEEKDAY) && day_bits[0]
                      && (rd_data.hr == r_req.hour) && (rd_data.mn == r_req.minute);

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_ptr       = r_ptr;
        n_status    = r_status;
        n_cm        = r_cm;
        n_cm_v      = r_cm_v;
        n_hold_v    = r_hold_v;
        n_hold_ch   = r_hold_ch;
        n_hold_on   = r_hold_on;
        rd_en       = 1'b0;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        push        = 1'b0;
        push_status = ST_OK;
        push_fire   = 1'b0;
        push_ch     = '0;
        push_on     = 1'b0;
        push_last   = 1'b0;
        nxt         = '0;
        mod_entry   = rd_data;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = ST_OK;
                    n_hold_v = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_command)
                        CMD_TICK: begin
                            if (!(r_cm_v && (i_minute == r_cm))) begin
                                n_cm   = i_minute;
                                n_cm_v = 1'b1;
                                if (r_total != '0) begin
                                    rd_en   = 1'b1;
                                    rd_addr = '0;
                                    n_ptr   = '0;
                                    n_state = S_CHK;
                                end
                            end
                        end
                        CMD_ADD: begin
                            if (!channel_ok(i_channel)) begin
                                n_status = ST_BAD_CHANNEL;
                            end else if (r_total >= CNT_W'(ENTRIES)) begin
                                n_status = ST_FULL;
                            end else begin
                                wr_en        = 1'b1;
                                wr_addr      = r_total[ADDR_W-1:0];
                                wr_data.ch   = i_channel;
                                wr_data.hr   = i_hour;
                                wr_data.mn   = i_minute;
                                wr_data.on   = i_turn_on;
                                wr_data.en   = 1'b1;
                                wr_data.days = i_day_mask;
                                n_total      = r_total + CNT_W'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (idx_cnt >= r_total) begin
                                n_status = ST_BAD_INDEX;
                            end else if (idx_cnt + CNT_W'(1) < r_total) begin
                                nxt     = idx_cnt + CNT_W'(1);
                                rd_en   = 1'b1;
                                rd_addr = nxt[ADDR_W-1:0];
                                n_ptr   = idx_cnt;
                                n_state = S_SHIFT;
                            end else begin
                                n_total = r_total - CNT_W'(1);
                            end
                        end
                        CMD_SET_EN: begin
                            if (idx_cnt >= r_total) begin
                                n_status = ST_BAD_INDEX;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = idx_cnt[ADDR_W-1:0];
                                n_state = S_RMW;
                            end
                        end
                        CMD_EDIT: begin
                            if (idx_cnt >= r_total) begin
                                n_status = ST_BAD_INDEX;
                            end else if (!channel_ok(i_channel)) begin
                                n_status = ST_BAD_CHANNEL;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = idx_cnt[ADDR_W-1:0];
                                n_state = S_RMW;
                            end
                        end
                        default: begin
                            // unknown command: no change, status ok
                        end
                    endcase
                end
            end
            S_CHK: begin
                // A second match must flush the held one; wait if output is busy.
                // The RAM read data holds meanwhile.
                if (!(match && r_hold_v && !out_free)) begin
                    if (match) begin
                        if (r_hold_v) begin
                            push      = 1'b1;
                            push_fire = 1'b1;
                            push_ch   = r_hold_ch;
                            push_on   = r_hold_on;
                        end
                        n_hold_v  = 1'b1;
                        n_hold_ch = rd_data.ch;
                        n_hold_on = rd_data.on;
                    end
                    nxt = r_ptr + CNT_W'(1);
                    if (nxt < r_total) begin
                        rd_en   = 1'b1;
                        rd_addr = nxt[ADDR_W-1:0];
                        n_ptr   = nxt;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                // rd_data is entry ptr+1; move it down to ptr
                wr_en   = 1'b1;
                wr_addr = r_ptr[ADDR_W-1:0];
                wr_data = rd_data;
                nxt     = r_ptr + CNT_W'(1);
                if (nxt + CNT_W'(1) < r_total) begin
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'(nxt + CNT_W'(1));
                    n_ptr   = nxt;
                end else begin
                    n_total = r_total - CNT_W'(1);
                    n_state = S_DONE;
                end
            end
            S_RMW: begin
                if (r_req.command == CMD_SET_EN) begin
                    mod_entry.en = r_req.enable;
                end else begin
                    mod_entry.ch   = r_req.channel;
                    mod_entry.hr   = r_req.hour;
                    mod_entry.mn   = r_req.minute;
                    mod_entry.on   = r_req.turn_on;
                    mod_entry.days = r_req.day_mask;
                end
                wr_en   = 1'b1;
                wr_addr = ADDR_W'(r_req.index);
                wr_data = mod_entry;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (r_hold_v) begin
                        push_fire = 1'b1;
                        push_ch   = r_hold_ch;
                        push_on   = r_hold_on;
                    end else begin
                        push_status = r_status;
                    end
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_cm        <= '0;
            r_cm_v      <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_cm     <= n_cm;
            r_cm_v   <= n_cm_v;
            r_hold_v <= n_hold_v;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_status  <= n_status;
        r_hold_ch <= n_hold_ch;
        r_hold_on <= n_hold_on;
        if (accept) begin
            r_req.command  <= i_command;
            r_req.index    <= i_index;
            r_req.channel  <= i_channel;
            r_req.hour     <= i_hour;
            r_req.minute   <= i_minute;
            r_req.weekday  <= i_weekday;
            r_req.turn_on  <= i_turn_on;
            r_req.enable   <= i_enable;
            r_req.day_mask <= i_day_mask;
        end
        if (push) begin
            r_out_status <= push_status;
            r_out_fire   <= push_fire;
            r_out_ch     <= push_ch;
            r_out_on     <= push_on;
            r_out_last   <= push_last;
            r_out_count  <= 5'(r_total);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_fire          = r_out_fire;
    assign o_relay_channel = r_out_ch;
    assign o_relay_on      = r_out_on;
    assign o_last          = r_out_last;
    assign o_entry_count   = r_out_count;

    // table never grows past its size
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= CNT_W'(ENTRIES))
        else $error("entry total exceeds table size");

    // entry total moves by at most one per transaction
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_total) |-> (r_total == $past(r_total) + CNT_W'(1))
                           || (r_total + CNT_W'(1) == $past(r_total)))
        else $error("entry total jumped");

    // a held match only exists during a tick walk or its final result
    a_hold_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_v |-> (r_state == S_CHK) || (r_state == S_DONE))
        else $error("held match outside tick walk");

    // relay commands always carry ok status
    a_fire_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fire) |-> (o_status == ST_OK))
        else $error("relay command with error status");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_free)
        else $error("output register overwritten");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for weekly_relay_schedule_table.
// Drives commands and time ticks, predicts every result and checks them in order.
// Depends on wrst_pkg and the RTL of the block only.
`default_nettype none

module tb_top;
    import wrst_pkg::*;

    localparam int QUIET_LIMIT = 4000;   // cycles with no transaction before giving up
    localparam int DRAIN_WAIT  = 60;     // > longest walk plus a few stalls
    localparam int ITEM_GOAL   = 350;
    localparam int IDLE_PCT    = 17;

    // one expected result transaction
    typedef struct packed {
        logic [1:0] status;
        logic       fire;
        logic [2:0] relay_ch;
        logic       relay_on;
        logic       last;
        logic [4:0] count;
    } t_relay_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [2:0] i_command = '0;
    logic [3:0] i_index = '0;
    logic [2:0] i_channel = '0;
    logic [4:0] i_hour = '0;
    logic [5:0] i_minute = '0;
    logic [2:0] i_weekday = '0;
    logic       i_turn_on = 1'b0;
    logic       i_enable = 1'b0;
    logic [6:0] i_day_mask = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [1:0] o_status;
    logic       o_fire;
    logic [2:0] o_relay_channel;
    logic       o_relay_on;
    logic       o_last;
    logic [4:0] o_entry_count;

    weekly_relay_schedule_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_index        (i_index),
        .i_channel      (i_channel),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_weekday      (i_weekday),
        .i_turn_on      (i_turn_on),
        .i_enable       (i_enable),
        .i_day_mask     (i_day_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_fire         (o_fire),
        .o_relay_channel(o_relay_channel),
        .o_relay_on     (o_relay_on),
        .o_last         (o_last),
        .o_entry_count  (o_entry_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_req          cmd_backlog[$];      // requests not yet put on the input port
    t_relay_result relay_expect_q[$];   // results predicted, not yet seen
    t_req          on_wire;             // request currently on the input port
    int            err_cnt = 0;
    int            sent_cnt = 0;        // input transactions accepted
    int            quiet_cycles = 0;
    bit            wrapping_up = 1'b0;

    // no idling on either side while this window of transactions passes
    function automatic bit idle_roll();
        if (sent_cnt >= 150 && sent_cnt < 230)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        $display("ERROR: %s", msg);
    endtask

    function automatic void expect_result(input t_relay_result r);
        relay_expect_q.insert(relay_expect_q.size(), r);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: own copy of the schedule table
    // ------------------------------------------------------------------
    t_entry           sched_tbl[ENTRIES];
    logic [CNT_W-1:0] sched_count = '0;
    logic [5:0]       seen_minute = '0;
    bit               seen_valid = 1'b0;

    function automatic bit chan_legal(input logic [2:0] ch);
        return (ch != 3'd0) && (int'(ch) <= CHANNELS);
    endfunction

    // weekday 7 selects no day bit, so it never matches
    function automatic bit entry_fires(input int pos, input t_req rq);
        t_entry e;
        e = sched_tbl[pos];
        if (!e.en || rq.weekday > LAST_WEEKDAY)
            return 1'b0;
        return e.days[rq.weekday] && e.hr == rq.hour && e.mn == rq.minute;
    endfunction

    function automatic void predict_schedule(input t_req rq);
        t_relay_result r;
        int            hits;
        int            k;
        r = '0;
        r.last = 1'b1;
        hits = 0;
        k = 0;
        r.status = ST_OK;
        case (rq.command)
            CMD_TICK: begin
                // same minute as the last checked one: skipped, a single empty result
                if (!(seen_valid && rq.minute == seen_minute)) begin
                    seen_minute = rq.minute;
                    seen_valid = 1'b1;
                    for (int i = 0; i < sched_count; i++)
                        if (entry_fires(i, rq))
                            hits++;
                    for (int i = 0; i < sched_count; i++) begin
                        if (entry_fires(i, rq)) begin
                            k++;
                            r.fire = 1'b1;
                            r.relay_ch = sched_tbl[i].ch;
                            r.relay_on = sched_tbl[i].on;
                            r.last = (k == hits);
                            r.count = sched_count;
                            expect_result(r);
                        end
                    end
                end
            end
            CMD_ADD: begin
                // channel is checked ahead of the table-full check
                if (!chan_legal(rq.channel)) begin
                    r.status = ST_BAD_CHANNEL;
                end else if (sched_count >= ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    sched_tbl[sched_count] = '{ch: rq.channel, hr: rq.hour, mn: rq.minute,
                                               on: rq.turn_on, en: 1'b1, days: rq.day_mask};
                    sched_count++;
                end
            end
            CMD_REMOVE: begin
                if (rq.index >= sched_count) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (int i = rq.index; i + 1 < sched_count; i++)
                        sched_tbl[i] = sched_tbl[i + 1];
                    sched_count--;
                end
            end
            CMD_SET_EN: begin
                if (rq.index >= sched_count)
                    r.status = ST_BAD_INDEX;
                else
                    sched_tbl[rq.index].en = rq.enable;
            end
            CMD_EDIT: begin
                // index before channel; the enabled flag is kept
                if (rq.index >= sched_count) begin
                    r.status = ST_BAD_INDEX;
                end else if (!chan_legal(rq.channel)) begin
                    r.status = ST_BAD_CHANNEL;
                end else begin
                    sched_tbl[rq.index].ch = rq.channel;
                    sched_tbl[rq.index].hr = rq.hour;
                    sched_tbl[rq.index].mn = rq.minute;
                    sched_tbl[rq.index].on = rq.turn_on;
                    sched_tbl[rq.index].days = rq.day_mask;
                end
            end
            default: ;  // unknown command: no change, status ok
        endcase
        if (hits == 0) begin
            r.fire = 1'b0;
            r.relay_ch = '0;
            r.relay_on = 1'b0;
            r.last = 1'b1;
            r.count = sched_count;
            expect_result(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: holds a request until accepted, then maybe idles
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_schedule(on_wire);
                sent_cnt++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_backlog.size() != 0 && !idle_roll()) begin
                    on_wire = cmd_backlog.pop_front();
                    i_command  <= on_wire.command;
                    i_index    <= on_wire.index;
                    i_channel  <= on_wire.channel;
                    i_hour     <= on_wire.hour;
                    i_minute   <= on_wire.minute;
                    i_weekday  <= on_wire.weekday;
                    i_turn_on  <= on_wire.turn_on;
                    i_enable   <= on_wire.enable;
                    i_day_mask <= on_wire.day_mask;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_error($sformatf("result %0s: got %0d, expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : monitor
        t_relay_result want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (relay_expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected result: status %0d fire %0d ch %0d",
                                         o_status, o_fire, o_relay_channel));
                end else begin
                    want = relay_expect_q.pop_front();
                    check_field("status", o_status, want.status);
                    check_field("fire", o_fire, want.fire);
                    check_field("relay_channel", o_relay_channel, want.relay_ch);
                    check_field("relay_on", o_relay_on, want.relay_on);
                    check_field("last", o_last, want.last);
                    check_field("entry_count", o_entry_count, want.count);
                end
            end
            i_out_stall <= idle_roll();
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any transaction on either channel
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && !wrapping_up) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    int gen_count = 0;   // table size as the generator tracks it, to aim indexes
    int gen_total = 0;

    function automatic t_req rand_req();
        t_req rq;
        rq.command  = 3'($urandom_range(0, 7));
        rq.index    = 4'($urandom_range(0, 15));
        rq.channel  = 3'($urandom_range(0, 7));
        rq.hour     = 5'($urandom_range(0, 31));
        rq.minute   = 6'($urandom_range(0, 63));
        rq.weekday  = 3'($urandom_range(0, 7));
        rq.turn_on  = 1'($urandom_range(0, 1));
        rq.enable   = 1'($urandom_range(0, 1));
        rq.day_mask = 7'($urandom_range(0, 127));
        return rq;
    endfunction

    task automatic push_item(input t_req rq);
        if (rq.command == CMD_ADD && chan_legal(rq.channel) && gen_count < ENTRIES)
            gen_count++;
        else if (rq.command == CMD_REMOVE && rq.index < gen_count)
            gen_count--;
        cmd_backlog.insert(cmd_backlog.size(), rq);
        gen_total++;
    endtask

    task automatic queue_cmd(input logic [2:0] cmd, input int idx, input int ch, input int hr,
                             input int mn, input int wd, input bit on, input bit en,
                             input int days);
        t_req rq;
        rq = '{command: cmd, index: 4'(idx), channel: 3'(ch), hour: 5'(hr),
               minute: 6'(mn), weekday: 3'(wd), turn_on: on, enable: en,
               day_mask: 7'(days)};
        push_item(rq);
    endtask

    function automatic int pick_index();
        if (gen_count > 0 && $urandom_range(0, 9) != 0)
            return $urandom_range(0, gen_count - 1);
        return $urandom_range(0, 15);
    endfunction

    // One scenario: load entries around a target time, tweak some, tick at it.
    // A fill scenario runs the table past full with entries at the tick time on every weekday.
    task automatic run_episode(input bit fill);
        t_req       rq;
        logic [4:0] t_hr;
        logic [5:0] t_mn;
        int         n;
        t_hr = 5'($urandom_range(0, 23));
        t_mn = 6'($urandom_range(0, 59));
        if (!fill && $urandom_range(0, 9) == 0) begin
            t_hr = 5'($urandom_range(0, 31));
            t_mn = 6'($urandom_range(0, 63));
        end
        n = fill ? ENTRIES + 2 - gen_count : $urandom_range(1, 5);
        repeat (n) begin
            rq = rand_req();
            rq.command = CMD_ADD;
            if (fill || $urandom_range(0, 9) != 0)
                rq.channel = 3'($urandom_range(1, CHANNELS));
            if (fill || $urandom_range(0, 9) < 7) begin
                rq.hour = t_hr;
                rq.minute = t_mn;
            end
            if (fill || $urandom_range(0, 2) == 0)
                rq.day_mask = 7'h7f;
            push_item(rq);
        end
        if (!fill) begin
            repeat ($urandom_range(0, 3)) begin
                rq = rand_req();
                case ($urandom_range(0, 2))
                    0: rq.command = CMD_REMOVE;
                    1: rq.command = CMD_SET_EN;
                    default: begin
                        rq.command = CMD_EDIT;
                        if ($urandom_range(0, 9) != 0)
                            rq.channel = 3'($urandom_range(1, CHANNELS));
                        if ($urandom_range(0, 4) < 3) begin
                            rq.hour = t_hr;
                            rq.minute = t_mn;
                        end
                    end
                endcase
                rq.index = 4'(pick_index());
                push_item(rq);
            end
        end
        rq = rand_req();
        rq.command = CMD_TICK;
        rq.hour = t_hr;
        rq.minute = t_mn;
        rq.weekday = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
        push_item(rq);
        if ($urandom_range(0, 2) == 0)
            push_item(rq);      // same minute again, gets skipped
        if ($urandom_range(0, 1) == 0) begin
            rq = rand_req();
            rq.command = CMD_TICK;
            push_item(rq);
        end
        repeat ($urandom_range(0, 1))
            push_item(rand_req());
        // keep room in the table for later scenarios
        while (gen_count > (fill ? 3 : 10)) begin
            rq = rand_req();
            rq.command = CMD_REMOVE;
            rq.index = 4'($urandom_range(0, gen_count - 1));
            push_item(rq);
        end
    endtask

    initial begin : stimulus
        bit first;
        // directed part
        queue_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);          // first tick, empty table
        queue_cmd(CMD_TICK, 0, 0, 0, 0, 3, 0, 0, 0);          // same minute: skipped
        queue_cmd(CMD_ADD, 0, 0, 5, 10, 0, 1, 0, 127);        // channel zero
        queue_cmd(CMD_ADD, 15, 7, 5, 10, 0, 1, 1, 127);       // channel seven
        queue_cmd(CMD_ADD, 0, 6, 31, 63, 0, 1, 0, 127);       // out-of-range time kept
        queue_cmd(CMD_ADD, 0, 1, 0, 0, 0, 0, 0, 0);
        queue_cmd(CMD_SET_EN, 15, 0, 0, 0, 0, 0, 1, 0);       // bad index
        queue_cmd(CMD_EDIT, 15, 0, 0, 0, 0, 0, 0, 0);         // index checked first
        queue_cmd(CMD_EDIT, 1, 0, 0, 0, 0, 0, 0, 0);          // bad channel
        queue_cmd(CMD_EDIT, 1, 3, 31, 63, 0, 0, 0, 1);
        queue_cmd(CMD_TICK, 0, 0, 31, 63, 0, 0, 0, 0);        // two matches
        queue_cmd(CMD_TICK, 0, 0, 31, 63, 0, 0, 0, 0);        // skipped
        queue_cmd(CMD_TICK, 0, 0, 31, 62, 7, 0, 0, 0);        // weekday seven
        queue_cmd(CMD_SET_EN, 0, 0, 0, 0, 0, 0, 0, 0);        // disable first entry
        queue_cmd(CMD_TICK, 0, 0, 31, 63, 0, 0, 0, 0);        // only second matches
        queue_cmd(3'd5, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(3'd6, 15, 7, 31, 63, 7, 1, 1, 127);
        queue_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_cmd(CMD_SET_EN, 0, 0, 0, 0, 0, 0, 1, 0);
        queue_cmd(CMD_REMOVE, 5, 0, 0, 0, 0, 0, 0, 0);        // bad index
        queue_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);        // shift down
        queue_cmd(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0);        // table empty again
        queue_cmd(CMD_TICK, 0, 0, 23, 59, 6, 0, 0, 0);

        // random part; the first scenario always fills the table
        first = 1'b1;
        while (gen_total < ITEM_GOAL) begin
            run_episode(first || $urandom_range(0, 7) == 0);
            first = 1'b0;
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: everything sent and every prediction matched
        while (cmd_backlog.size() != 0 || i_in_valid || relay_expect_q.size() != 0)
            @(posedge i_clk);
        wrapping_up = 1'b1;
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (err_cnt == 0 && relay_expect_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
